>>> src/haws_pkg.sv
// Package: shared types and codes for the health-aware weighted selector.
package haws_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam logic [15:0] RTT_UNKNOWN = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_PICK    = 3'd0,
		OP_RACE    = 3'd1,
		OP_SUCCESS = 3'd2,
		OP_FAILURE = 3'd3,
		OP_RELEASE = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		SEL_FIXED   = 3'd0,
		SEL_RR      = 3'd1,
		SEL_RANDOM  = 3'd2,
		SEL_RACE    = 3'd3,
		SEL_HEALTHY = 3'd4,
		SEL_LEAST   = 3'd5,
		SEL_WEIGHT  = 3'd6,
		SEL_SPARE   = 3'd7
	} sel_t;

	typedef enum logic [2:0] {
		REG_ENTRY_COUNT = 3'd0,
		REG_SEL_MODE    = 3'd1,
		REG_RACE_TRIES  = 3'd2,
		REG_MAX_FAIL    = 3'd3,
		REG_MIN_UNUSED  = 3'd4,
		REG_WEIGHTS     = 3'd5
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_FILTER,
		ST_MOD,
		ST_SCAN,
		ST_WMOD,
		ST_WSCAN,
		ST_RACE1,
		ST_RACE2,
		ST_EMIT,
		ST_EVENT
	} state_t;

endpackage

>>> src/health_aware_weighted_selector.sv
// Top level: health-aware weighted pool selector with APB-style register port.
// Usage: pulse start while busy is low; the item is taken at that edge and busy rises,
// save on a race with max_picks zero or a mode code above 4. A pick or event reports
// one word on picked_index/last/entry_healthy, marked by valid for one cycle; a race
// pick reports up to eight words, one per cycle, the final one with last set. Results
// cannot be held off, so capture them when valid is high. One shared scan unit visits
// one entry per cycle, and a restoring modulo yields one quotient bit per cycle. The
// last word of a pick, race or event comes in the last cycle that busy is high. Entry
// state lives in flip-flops set at reset; there is no clearing pass.
module health_aware_weighted_selector
	import haws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [2:0]  entry_index,
	input  logic [15:0] rtt_sample_ms,
	input  logic        counts_as_active,
	input  logic [2:0]  random_start,
	input  logic [3:0]  max_picks,
	output logic        valid,
	output logic [2:0]  picked_index,
	output logic        last,
	output logic        entry_healthy
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int RW = 16;
	localparam logic [RW-1:0] UNK = RTT_UNKNOWN;
	localparam int TW = CW + 8;   // total weight width

	// Register file
	logic [3:0]  entry_count_q, race_tries_q;
	logic [2:0]  selection_mode_q;
	logic [7:0]  max_failures_q, min_unused_q;
	logic [63:0] weights_packed_q;

	// Entry state
	logic [MAX_ENTRIES-1:0] healthy_q;
	logic [7:0]  fail_q   [MAX_ENTRIES];
	logic [RW-1:0] rtt_q  [MAX_ENTRIES];
	logic [15:0] active_q [MAX_ENTRIES];
	logic [31:0] rotate_q, wcount_q;

	state_t state_q, state_d;

	// Latched item
	logic [2:0]  op_q, idx_q;
	logic [15:0] smp_q;
	logic        act_q;
	logic [2:0]  rnd_q;
	logic [3:0]  lim_q;

	// Scan unit
	logic [CW-1:0] n_q;
	logic [IW-1:0] ptr_q;       // current entry
	logic [CW-1:0] steps_q;     // entries visited
	logic [CW-1:0] cnt_h_q, cnt_q_q, cnt_hq_q;
	logic          need_h_q, need_q_q;
	logic [IW-1:0] base_q;
	logic [RW-1:0] low_rtt_q;
	logic          found_q;
	logic [TW-1:0] total_q, sum_q;
	logic          wpass_q;     // weighted: 0 = total, 1 = select
	// Modulo unit
	logic [31:0]   dvd_q;
	logic [TW-1:0] rem_q, div_q;
	logic [5:0]    mbit_q;
	logic          mod_for_w_q;
	// Race / output queue
	logic [IW-1:0] pk_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] mask_q;
	logic [CW-1:0] sel_q, emit_q;

	assign pready = 1'b1;
	assign busy   = (state_q != ST_IDLE);

	wire accept = start && !busy;
	wire wr     = psel && penable && pwrite;
	wire [2:0] ra = paddr[5:3];

	// Derived config
	logic [CW-1:0] n_use;
	always_comb begin
		if (entry_count_q == 4'd0) n_use = CW'(1);
		else if (32'(entry_count_q) > MAX_ENTRIES) n_use = CW'(MAX_ENTRIES);
		else n_use = CW'(entry_count_q);
	end

	function automatic logic [7:0] wt(input logic [63:0] w, input int i);
		logic [7:0] b;
		b = (i < 8) ? w[(i%8)*8 +: 8] : 8'd1;
		return (b == 8'd0) ? 8'd1 : b;
	endfunction

	// Current entry attributes
	logic cur_h, cur_qok, cur_ok;
	logic [RW-1:0] cur_rtt;
	logic [7:0] cur_w;
	always_comb begin
		cur_h   = healthy_q[ptr_q];
		cur_qok = (min_unused_q == 8'd0) || (active_q[ptr_q] < {8'd0, min_unused_q});
		cur_ok  = (!need_h_q || cur_h) && (!need_q_q || cur_qok);
		cur_rtt = rtt_q[ptr_q];
		cur_w   = 8'd1;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (ptr_q == IW'(i)) cur_w = wt(weights_packed_q, i);
	end

	wire [IW-1:0] ptr_nx = (32'(ptr_q) + 1 >= 32'(n_q)) ? '0 : ptr_q + IW'(1);
	wire scan_end = (steps_q + CW'(1) >= n_q);

	// Modulo step
	wire [TW:0] rem_sh = {rem_q, dvd_q[31]};
	wire        rem_ge = (rem_sh >= {1'b0, div_q});
	wire [TW:0] rem_nx = rem_ge ? rem_sh - {1'b0, div_q} : rem_sh;

	// Event arithmetic
	wire [IW-1:0] eidx = idx_q[IW-1:0];
	wire ev_ok = (CW'(idx_q) < n_q) && (32'(idx_q) < MAX_ENTRIES);
	wire [15:0] smp_sat = (smp_q >= UNK) ? UNK - 16'd1 : smp_q;
	wire [18:0] ewma = ({3'd0, rtt_q[eidx]} * 19'd7 + {3'd0, smp_sat}) >> 3;
	wire [7:0] fail_nx = (fail_q[eidx] == 8'hFF) ? 8'hFF : fail_q[eidx] + 8'd1;
	wire [3:0] rlim0 = (race_tries_q == 4'd0) ? 4'd1 : race_tries_q;
	wire [3:0] rlim1 = (rlim0 > lim_q) ? lim_q : rlim0;
	wire [3:0] rlim  = (32'(rlim1) > 32'(n_q)) ? 4'(n_q) : rlim1;

	// Health flag of the event's entry as it stands after the event
	logic ev_health;
	always_comb begin
		ev_health = (32'(idx_q) < MAX_ENTRIES) ? healthy_q[eidx] : 1'b1;
		if (ev_ok) begin
			case (op_q)
				OP_SUCCESS: ev_health = 1'b1;
				OP_FAILURE: if (fail_nx >= max_failures_q) ev_health = 1'b0;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (accept) begin
					case (mode)
						OP_PICK: state_d = (n_use <= CW'(1)) ? ST_EMIT : ST_COUNT;
						OP_RACE: state_d = (max_picks == 4'd0) ? ST_IDLE : ST_COUNT;
						OP_SUCCESS, OP_FAILURE, OP_RELEASE: state_d = ST_EVENT;
						default: state_d = ST_IDLE;
					endcase
				end
			ST_COUNT:  if (scan_end) state_d = ST_FILTER;
			ST_FILTER: state_d = ST_MOD;
			ST_MOD:
				if (mbit_q == 6'd0) begin
					if (mod_for_w_q || (selection_mode_q == SEL_WEIGHT && op_q == OP_PICK))
						state_d = ST_WSCAN;
					else if (op_q == OP_RACE) state_d = ST_RACE1;
					else state_d = ST_SCAN;
				end
			ST_SCAN:
				if (scan_end || (cur_ok && selection_mode_q != SEL_LEAST &&
				    selection_mode_q != SEL_WEIGHT)) state_d = ST_EMIT;
			ST_WSCAN:
				if (!wpass_q) begin
					if (scan_end) state_d = ST_WMOD;
				end else if ((cur_ok && (rem_q < sum_q + TW'(cur_w))) || scan_end)
					state_d = ST_EMIT;
			ST_WMOD:   state_d = ST_MOD;
			ST_RACE1, ST_RACE2:
				if (sel_q >= CW'(lim_q) || (scan_end && state_q == ST_RACE2))
					state_d = ST_EMIT;
				else if (scan_end) state_d = ST_RACE2;
			ST_EMIT:   if (emit_q + CW'(1) >= sel_q) state_d = ST_IDLE;
			ST_EVENT:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output word
	always_comb begin
		valid = 1'b0;
		picked_index = 3'(pk_q[emit_q[IW-1:0]]);
		last = (emit_q + CW'(1) >= sel_q);
		entry_healthy = healthy_q[pk_q[emit_q[IW-1:0]]];
		if (state_q == ST_EMIT) valid = 1'b1;
		if (state_q == ST_EVENT) begin
			valid = 1'b1;
			picked_index = idx_q;
			last = 1'b1;
			entry_healthy = ev_health;
		end
	end

	always_comb begin
		prdata = '0;
		case (ra)
			REG_ENTRY_COUNT: prdata = {60'd0, entry_count_q};
			REG_SEL_MODE:    prdata = {61'd0, selection_mode_q};
			REG_RACE_TRIES:  prdata = {60'd0, race_tries_q};
			REG_MAX_FAIL:    prdata = {56'd0, max_failures_q};
			REG_MIN_UNUSED:  prdata = {56'd0, min_unused_q};
			REG_WEIGHTS:     prdata = weights_packed_q;
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_count_q <= 4'd1;
			selection_mode_q <= 3'd0;
			race_tries_q <= 4'd1;
			max_failures_q <= 8'd3;
			min_unused_q <= 8'd0;
			weights_packed_q <= 64'h0101010101010101;
			healthy_q <= '1;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				fail_q[i] <= '0;
				rtt_q[i] <= UNK;
				active_q[i] <= '0;
			end
			rotate_q <= '0;
			wcount_q <= '0;
			sel_q <= '0;
			emit_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr) begin
				case (ra)
					REG_ENTRY_COUNT: entry_count_q <= pwdata[3:0];
					REG_SEL_MODE:    selection_mode_q <= pwdata[2:0];
					REG_RACE_TRIES:  race_tries_q <= pwdata[3:0];
					REG_MAX_FAIL:    max_failures_q <= pwdata[7:0];
					REG_MIN_UNUSED:  min_unused_q <= pwdata[7:0];
					REG_WEIGHTS:     weights_packed_q <= pwdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (accept) begin
					op_q <= mode; idx_q <= entry_index; smp_q <= rtt_sample_ms;
					act_q <= counts_as_active; rnd_q <= random_start; lim_q <= max_picks;
					n_q <= n_use;
					ptr_q <= '0; steps_q <= '0;
					cnt_h_q <= '0; cnt_q_q <= '0; cnt_hq_q <= '0;
					need_h_q <= 1'b0; need_q_q <= 1'b0;
					emit_q <= '0; sel_q <= CW'(1);
					mask_q <= '0; total_q <= '0; sum_q <= '0;
					wpass_q <= 1'b0; mod_for_w_q <= 1'b0; found_q <= 1'b0;
					pk_q[0] <= '0;
				end
				ST_COUNT: begin
					// Tally health, quota and joint passes, one entry a cycle
					if (cur_h) cnt_h_q <= cnt_h_q + CW'(1);
					if (cur_qok) cnt_q_q <= cnt_q_q + CW'(1);
					if (cur_h && cur_qok) cnt_hq_q <= cnt_hq_q + CW'(1);
					ptr_q <= ptr_nx; steps_q <= steps_q + CW'(1);
				end
				ST_FILTER: begin
					// Drop a filter that nothing passes; set up counter, random start or zero mod n
					if (op_q == OP_RACE) begin
						need_h_q <= (cnt_h_q != '0);
						need_q_q <= (min_unused_q != 8'd0) &&
							((cnt_h_q != '0) ? (cnt_hq_q != '0) : (cnt_q_q != '0));
						sel_q <= '0;
						rotate_q <= rotate_q + 32'(rlim);
						lim_q <= rlim;
					end else begin
						logic nh, nq;
						nh = (selection_mode_q == SEL_HEALTHY || selection_mode_q == SEL_LEAST);
						nq = (min_unused_q != 8'd0) && (selection_mode_q != SEL_FIXED);
						if (nh && ((nq ? cnt_hq_q : cnt_h_q) == '0)) nh = 1'b0;
						if (nq && ((nh ? cnt_hq_q : cnt_q_q) == '0)) nq = 1'b0;
						if (selection_mode_q == SEL_RACE || selection_mode_q == SEL_SPARE)
							nh = 1'b0;
						need_h_q <= nh; need_q_q <= nq;
						if (selection_mode_q == SEL_RR || selection_mode_q == SEL_HEALTHY ||
						    selection_mode_q == SEL_LEAST || selection_mode_q == SEL_RACE ||
						    selection_mode_q == SEL_SPARE)
							rotate_q <= rotate_q + 32'd1;
					end
					if (op_q == OP_PICK && selection_mode_q == SEL_RANDOM)
						dvd_q <= {29'd0, rnd_q};
					else if (op_q == OP_PICK && selection_mode_q == SEL_FIXED)
						dvd_q <= '0;
					else
						dvd_q <= rotate_q;
					rem_q <= '0; div_q <= TW'(n_q);
					// Weighted pick goes straight to the total pass
					mbit_q <= (op_q == OP_PICK && selection_mode_q == SEL_WEIGHT) ?
						6'd0 : 6'd32;
				end
				ST_MOD: begin
					if (mbit_q != 6'd0) begin
						// One quotient bit a cycle: remainder only
						rem_q <= rem_nx[TW-1:0];
						dvd_q <= {dvd_q[30:0], 1'b0};
						mbit_q <= mbit_q - 6'd1;
					end else begin
						steps_q <= '0;
						if (mod_for_w_q) begin
							ptr_q <= '0; wpass_q <= 1'b1; sum_q <= '0;
							wcount_q <= wcount_q + 32'd1;
						end else if (selection_mode_q == SEL_WEIGHT && op_q == OP_PICK &&
						             !wpass_q) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= rem_q[IW-1:0];
							base_q <= rem_q[IW-1:0];
							pk_q[0] <= (selection_mode_q == SEL_FIXED) ? '0 : rem_q[IW-1:0];
						end
					end
				end
				ST_SCAN: begin
					if (selection_mode_q == SEL_FIXED) begin
						pk_q[0] <= '0;
					end else if (selection_mode_q == SEL_LEAST) begin
						if (cur_ok && (!found_q || cur_rtt < low_rtt_q)) begin
							pk_q[0] <= ptr_q; low_rtt_q <= cur_rtt; found_q <= 1'b1;
						end
					end else if (cur_ok) begin
						pk_q[0] <= ptr_q;
					end
					ptr_q <= ptr_nx; steps_q <= steps_q + CW'(1);
				end
				ST_WSCAN: begin
					if (!wpass_q) begin
						if (cur_ok) total_q <= total_q + TW'(cur_w);
					end else begin
						if (cur_ok) sum_q <= sum_q + TW'(cur_w);
						if (cur_ok && rem_q < sum_q + TW'(cur_w))
							pk_q[0] <= ptr_q;
						else if (scan_end)
							pk_q[0] <= IW'(n_q - CW'(1));
					end
					ptr_q <= ptr_nx; steps_q <= steps_q + CW'(1);
				end
				ST_WMOD: begin
					// All filtered totals are nonzero, so total mod is safe
					dvd_q <= wcount_q; rem_q <= '0; div_q <= total_q;
					mbit_q <= 6'd32; mod_for_w_q <= 1'b1;
				end
				ST_RACE1, ST_RACE2: begin
					if (sel_q < CW'(lim_q)) begin
						if ((state_q == ST_RACE1) ? cur_ok : !mask_q[ptr_q]) begin
							pk_q[sel_q[IW-1:0]] <= ptr_q;
							mask_q[ptr_q] <= 1'b1;
							sel_q <= sel_q + CW'(1);
						end
					end
					ptr_q <= scan_end ? base_q : ptr_nx;
					steps_q <= scan_end ? '0 : steps_q + CW'(1);
				end
				ST_EMIT: emit_q <= emit_q + CW'(1);
				ST_EVENT: if (ev_ok) begin
					case (op_q)
						OP_SUCCESS: begin
							fail_q[eidx] <= '0;
							healthy_q[eidx] <= 1'b1;
							rtt_q[eidx] <= (rtt_q[eidx] == UNK) ? smp_sat : ewma[15:0];
							if (act_q && active_q[eidx] != 16'hFFFF)
								active_q[eidx] <= active_q[eidx] + 16'd1;
						end
						OP_FAILURE: begin
							fail_q[eidx] <= fail_nx;
							if (fail_nx >= max_failures_q) healthy_q[eidx] <= 1'b0;
						end
						OP_RELEASE:
							if (active_q[eidx] != 16'd0) active_q[eidx] <= active_q[eidx] - 16'd1;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule
